// ===== hdl/ithpe_pkg.sv =====
// Package: shared types, codes and constants of the interrupt program engine.
`timescale 1ns / 1ps
package ithpe_pkg;

  localparam int unsigned ProgDepthDefault    = 32;
  localparam int unsigned ScratchCountDefault = 6;
  localparam int unsigned RunLimit            = 32;
  localparam int unsigned LenW                = 6;

  // input operations
  localparam logic [1:0] OP_CMD  = 2'd0;
  localparam logic [1:0] OP_IRQ  = 2'd1;
  localparam logic [1:0] OP_DATA = 2'd2;

  // command codes
  localparam logic [3:0] C_RD8   = 4'd0;
  localparam logic [3:0] C_RD16  = 4'd1;
  localparam logic [3:0] C_RD32  = 4'd2;
  localparam logic [3:0] C_WI8   = 4'd3;
  localparam logic [3:0] C_WI16  = 4'd4;
  localparam logic [3:0] C_WI32  = 4'd5;
  localparam logic [3:0] C_WR8   = 4'd6;
  localparam logic [3:0] C_WR16  = 4'd7;
  localparam logic [3:0] C_WR32  = 4'd8;
  localparam logic [3:0] C_LOAD  = 4'd9;
  localparam logic [3:0] C_AND   = 4'd10;
  localparam logic [3:0] C_SKIP  = 4'd11;
  localparam logic [3:0] C_ACPT  = 4'd12;
  localparam logic [3:0] C_DECL  = 4'd13;

  // result kinds
  localparam logic [2:0] K_OK   = 3'd0;
  localparam logic [2:0] K_ERR  = 3'd1;
  localparam logic [2:0] K_RD   = 3'd2;
  localparam logic [2:0] K_WR   = 3'd3;
  localparam logic [2:0] K_ACPT = 3'd4;
  localparam logic [2:0] K_DECL = 3'd5;
  localparam logic [2:0] K_REJ  = 3'd6;

  // config register indexes
  localparam logic [0:0] R_LEN = 1'd0;
  localparam logic [0:0] R_EN  = 1'd1;

  typedef struct packed {
    logic [1:0]  operation;
    logic [4:0]  slot;
    logic [3:0]  command_code;
    logic [2:0]  source_reg;
    logic [2:0]  dest_reg;
    logic [31:0] immediate;
    logic [31:0] port_address;
    logic [31:0] read_data;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] access_address;
    logic [2:0]  access_bytes;
    logic [31:0] write_value;
    logic [31:0] sequence_res;
    logic [31:0] arg_one;
    logic [31:0] arg_two;
    logic [31:0] arg_three;
    logic [31:0] arg_four;
    logic [31:0] arg_five;
    logic        last;
  } out_item_t;

  // controller -> datapath commands
  typedef struct packed {
    logic take_in;    // latch input item
    logic cmd_write;  // store command (if valid) and emit ok/err
    logic fetch;      // read store at pc
    logic exec;       // execute fetched command
    logic rd_done;    // write returned read data
    logic emit_simple;// emit a kind-only result
    logic [2:0] simple_kind;
    logic pc_clear;
  } ctl_t;

  // datapath -> controller status
  typedef struct packed {
    logic [1:0] op;
    logic       run_end;    // pc at or past run length
    logic       ends_item;  // executed command ends the item (read/accept/decline)
    logic       is_read;
    logic       emits;      // executed command emits a result
  } sts_t;

  function automatic logic [2:0] size_of(input logic [3:0] code);
    logic [3:0] m;
    m = (code < 4'd3) ? code : (code < 4'd6) ? code - 4'd3 : code - 4'd6;
    return (m == 4'd0) ? 3'd1 : (m == 4'd1) ? 3'd2 : 3'd4;
  endfunction

  function automatic logic [31:0] trunc_to(input logic [31:0] v, input logic [2:0] b);
    return (b == 3'd1) ? {24'd0, v[7:0]} : (b == 3'd2) ? {16'd0, v[15:0]} : v;
  endfunction

endpackage

// ===== hdl/ithpe_if.sv =====
// Interfaces: valid/ready item channel and configuration write channel.
`timescale 1ns / 1ps
interface ithpe_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ithpe_cfg_if ();
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [31:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== hdl/ithpe_ctrl.sv =====
// Controller: sequences command writes, program runs and port-read pauses.
`timescale 1ns / 1ps
module ithpe_ctrl
  import ithpe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       out_busy_i,  // output register full and not taken
  input  logic       awaiting_i,
  input  logic       enable_i,
  input  sts_t       sts_i,
  output ctl_t       ctl_o
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.take_in = 1'b1;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        if (!out_busy_i) begin
          state_d = S_IDLE;
          if (sts_i.op == OP_CMD) begin
            ctl_o.cmd_write = 1'b1;
          end else if (sts_i.op == OP_IRQ && !awaiting_i) begin
            if (!enable_i) begin
              ctl_o.emit_simple = 1'b1;
              ctl_o.simple_kind = K_DECL;
              ctl_o.pc_clear = 1'b1;
            end else begin
              ctl_o.pc_clear = 1'b1;
              state_d = S_FETCH;
            end
          end else if (sts_i.op == OP_DATA && awaiting_i) begin
            ctl_o.rd_done = 1'b1;
            state_d = S_FETCH;
          end else begin
            ctl_o.emit_simple = 1'b1;
            ctl_o.simple_kind = K_REJ;
          end
        end
      end
      S_FETCH: begin
        if (sts_i.run_end) begin
          state_d = S_DONE;
        end else begin
          ctl_o.fetch = 1'b1;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!(sts_i.emits && out_busy_i)) begin
          ctl_o.exec = 1'b1;
          state_d = sts_i.ends_item ? S_IDLE : S_FETCH;
        end
      end
      S_DONE: begin
        if (!out_busy_i) begin
          ctl_o.emit_simple = 1'b1;
          ctl_o.simple_kind = K_DECL;
          ctl_o.pc_clear = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end
endmodule

// ===== hdl/ithpe_dp.sv =====
// Datapath: program store, scratch registers, counters and result register.
`timescale 1ns / 1ps
module ithpe_dp
  import ithpe_pkg::*;
#(
  parameter int unsigned PROG_DEPTH    = ProgDepthDefault,
  parameter int unsigned SCRATCH_COUNT = ScratchCountDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  in_item_t    in_i,
  input  ctl_t        ctl_i,
  output sts_t        sts_o,
  input  logic [LenW-1:0] prog_len_i,
  output logic        awaiting_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_o
);
  localparam int unsigned AW  = (PROG_DEPTH > 1) ? $clog2(PROG_DEPTH) : 1;
  localparam int unsigned PCW = $clog2(PROG_DEPTH + 1) > LenW ? $clog2(PROG_DEPTH + 1) : LenW;
  localparam int unsigned LimVal = (RunLimit < PROG_DEPTH) ? RunLimit : PROG_DEPTH;
  localparam logic [PCW-1:0] Lim = PCW'(LimVal);

  logic [41:0] cmd_mem [PROG_DEPTH];
  logic [31:0] adr_mem [PROG_DEPTH];
  logic [41:0] cmd_q;
  logic [31:0] adr_q;
  logic [31:0] scr_q [SCRATCH_COUNT];
  logic [31:0] scr_d [SCRATCH_COUNT];
  logic [PCW-1:0] pc_q, pc_d;
  logic        await_q, await_d;
  logic [2:0]  pdst_q, pdst_d;
  logic [2:0]  pbytes_q, pbytes_d;
  logic [31:0] ncnt_q, ncnt_d;
  in_item_t    in_q;
  logic        ov_q, ov_d;
  out_item_t   o_q, o_d;

  // run length
  logic [PCW-1:0] len_ext, run_len;
  assign len_ext = PCW'(prog_len_i);
  assign run_len = (len_ext > Lim) ? Lim : len_ext;

  // command write check
  logic bad;
  always_comb begin
    bad = (in_q.command_code >= 4'd14)
       || (32'(in_q.source_reg) >= 32'(SCRATCH_COUNT))
       || (32'(in_q.dest_reg) >= 32'(SCRATCH_COUNT))
       || (32'(in_q.slot) >= 32'(PROG_DEPTH));
    if (in_q.command_code == C_SKIP &&
        (33'(in_q.slot) + 33'(in_q.immediate)) > 33'(prog_len_i)) bad = 1'b1;
  end

  // decode fetched command
  logic [3:0]  code;
  logic [2:0]  src, dst, bytes;
  logic [31:0] imm, srcv;
  assign code  = cmd_q[3:0];
  assign src   = cmd_q[6:4];
  assign dst   = cmd_q[9:7];
  assign imm   = cmd_q[41:10];
  assign bytes = size_of(code);
  always_comb begin
    srcv = '0;
    for (int i = 0; i < SCRATCH_COUNT; i++)
      if (32'(src) == i) srcv = scr_q[i];
  end

  // next pc for sequential commands
  logic [32+PCW-1:0] nxt;
  logic [PCW-1:0]    nxt_pc;
  always_comb begin
    nxt = (32+PCW)'(pc_q) + 1'b1;
    if (code == C_SKIP && srcv == '0) nxt = nxt + (32+PCW)'(imm);
    nxt_pc = (nxt >= (32+PCW)'(run_len)) ? run_len : nxt[PCW-1:0];
  end

  always_comb begin
    sts_o.op        = in_q.operation;
    sts_o.run_end   = pc_q >= run_len;
    sts_o.is_read   = code <= C_RD32;
    sts_o.ends_item = code <= C_RD32 || code == C_ACPT || code >= C_DECL;
    sts_o.emits     = code <= C_WR32 || code == C_ACPT || code >= C_DECL;
  end
  assign awaiting_o  = await_q;
  assign out_valid_o = ov_q;
  assign out_o       = o_q;

  // store and input capture (no reset)
  always_ff @(posedge clk_i) begin
    if (ctl_i.take_in) in_q <= in_i;
    if (ctl_i.cmd_write && !bad) begin
      cmd_mem[AW'(in_q.slot)] <= {in_q.immediate, in_q.dest_reg,
                                  in_q.source_reg, in_q.command_code};
      adr_mem[AW'(in_q.slot)] <= in_q.port_address;
    end
    if (ctl_i.fetch) begin
      cmd_q <= cmd_mem[pc_q[AW-1:0]];
      adr_q <= adr_mem[pc_q[AW-1:0]];
    end
  end

  // next state of the engine registers
  always_comb begin
    scr_d    = scr_q;
    pc_d     = pc_q;
    await_d  = await_q;
    pdst_d   = pdst_q;
    pbytes_d = pbytes_q;
    ncnt_d   = ncnt_q;
    ov_d     = ov_q;
    o_d      = o_q;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    if (ctl_i.pc_clear) begin
      pc_d = '0; await_d = 1'b0;
    end
    if (ctl_i.emit_simple || ctl_i.cmd_write) begin
      ov_d = 1'b1;
      o_d = '0;
      o_d.kind = ctl_i.cmd_write ? (bad ? K_ERR : K_OK) : ctl_i.simple_kind;
      o_d.last = 1'b1;
    end
    if (ctl_i.rd_done) begin
      for (int i = 0; i < SCRATCH_COUNT; i++)
        if (32'(pdst_q) == i) scr_d[i] = trunc_to(in_q.read_data, pbytes_q);
      await_d = 1'b0;
      pc_d = pc_q + 1'b1;
    end
    if (ctl_i.exec) begin
      pc_d = nxt_pc;
      case (code)
        C_RD8, C_RD16, C_RD32: begin
          pdst_d = dst; pbytes_d = bytes; await_d = 1'b1;
          ov_d = 1'b1; o_d = '0; o_d.kind = K_RD;
          o_d.access_address = adr_q; o_d.access_bytes = bytes; o_d.last = 1'b1;
          pc_d = pc_q;
        end
        C_WI8, C_WI16, C_WI32, C_WR8, C_WR16, C_WR32: begin
          ov_d = 1'b1; o_d = '0; o_d.kind = K_WR;
          o_d.access_address = adr_q; o_d.access_bytes = bytes;
          o_d.write_value = trunc_to((code <= C_WI32) ? imm : srcv, bytes);
        end
        C_LOAD, C_AND: begin
          for (int i = 0; i < SCRATCH_COUNT; i++)
            if (32'(dst) == i) scr_d[i] = (code == C_LOAD) ? imm : (srcv & imm);
        end
        C_SKIP: ;
        C_ACPT: begin
          ncnt_d = ncnt_q + 1'b1;
          pc_d = '0; await_d = 1'b0;
          ov_d = 1'b1; o_d = '0; o_d.kind = K_ACPT;
          o_d.sequence_res = ncnt_q + 1'b1;
          o_d.arg_one = scr_q[1]; o_d.arg_two = scr_q[2];
          o_d.arg_three = scr_q[3]; o_d.arg_four = scr_q[4];
          o_d.arg_five = scr_q[5]; o_d.last = 1'b1;
        end
        default: begin
          pc_d = '0; await_d = 1'b0;
          ov_d = 1'b1; o_d = '0; o_d.kind = K_DECL; o_d.last = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SCRATCH_COUNT; i++) scr_q[i] <= '0;
      pc_q <= '0; await_q <= 1'b0; pdst_q <= '0; pbytes_q <= '0;
      ncnt_q <= '0; ov_q <= 1'b0; o_q <= '0;
    end else begin
      scr_q    <= scr_d;
      pc_q     <= pc_d;
      await_q  <= await_d;
      pdst_q   <= pdst_d;
      pbytes_q <= pbytes_d;
      ncnt_q   <= ncnt_d;
      ov_q     <= ov_d;
      o_q      <= o_d;
    end
  end
endmodule

// ===== hdl/irq_top_half_program_engine.sv =====
// Top level: interrupt program engine with config port, controller and datapath.
`timescale 1ns / 1ps
// A command write or a rejected item is taken in the idle state; its result is registered
// from the dispatch state once the output is free. An interrupt runs each program command
// as a fetch from the program store, then an execute; a program that runs off the end
// declines. A port read ends the transaction; read_data resumes at the next command.
// One input transaction at a time; the next is taken once the last result is registered.
// Reset (async, active low) clears scratch registers and counters and sets config to length
// zero, enabled; the program store has no reset and must be written before use.
module irq_top_half_program_engine
  import ithpe_pkg::*;
#(
  parameter int unsigned PROG_DEPTH    = ProgDepthDefault,
  parameter int unsigned SCRATCH_COUNT = ScratchCountDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  ithpe_cfg_if.sink                  cfg,
  ithpe_stream_if.sink               in_ch,
  ithpe_stream_if.source             out_ch
);
  // configuration registers
  logic [LenW-1:0] len_q;
  logic            en_q;
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      en_q  <= 1'b1;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        R_LEN:   len_q <= cfg.wdata[LenW-1:0];
        R_EN:    en_q  <= cfg.wdata[0];
        default: ;
      endcase
    end
  end

  ctl_t ctl;
  sts_t sts;
  logic awaiting, out_valid;
  in_item_t  in_item;
  out_item_t out_item;
  assign in_item = in_ch.data;

  ithpe_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .out_busy_i (out_valid && !out_ch.ready),
    .awaiting_i (awaiting),
    .enable_i   (en_q),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  ithpe_dp #(.PROG_DEPTH(PROG_DEPTH), .SCRATCH_COUNT(SCRATCH_COUNT)) u_dp (
    .clk_i, .rst_ni,
    .in_i        (in_item),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .prog_len_i  (len_q),
    .awaiting_o  (awaiting),
    .out_valid_o (out_valid),
    .out_ready_i (out_ch.ready),
    .out_o       (out_item)
  );

  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_item;
endmodule

// ===== hdl/ithpe_checker.sv =====
// Checker: port-level assertions, bound to the top level.
`timescale 1ns / 1ps
module ithpe_port_checker
  import ithpe_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [2:0] kind,
  input logic [2:0] bytes,
  input logic last
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready) else $error("took item while busy");
  a_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (kind == K_RD || kind == K_WR) |-> (bytes == 3'd1 || bytes == 3'd2 ||
    bytes == 3'd4)) else $error("bad access size");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && kind != K_WR |-> last) else $error("missing last");
endmodule

bind irq_top_half_program_engine ithpe_port_checker u_chk (
  .clk_i, .rst_ni,
  .in_valid (in_ch.valid), .in_ready (in_ch.ready),
  .out_valid (out_ch.valid), .out_ready (out_ch.ready),
  .kind (out_ch.data.kind), .bytes (out_ch.data.access_bytes),
  .last (out_ch.data.last)
);
